[rtl/core/lmts_pkg.sv]
// Package for the LFSR memory test sequencer.
// Holds field widths, codes, result structs and the LFSR step function.
// No dependencies.
package lmts_pkg;

  localparam int WORD_ADDR_WIDTH_DEF = 29;
  localparam int ADDR_OUT_W          = 29;
  localparam int KEY_W               = 64;
  localparam int BLOCK_W             = 17;
  localparam int LAG_W               = 8;
  localparam int MEM_W               = 33;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 33;
  localparam int OUT_TDATA_W         = 160;
  localparam int OUT_TUSER_W         = 3;

  localparam logic [BLOCK_W-1:0] BLOCK_WORDS_RST = BLOCK_W'(1024 * 16);
  localparam logic [LAG_W-1:0]   VERIFY_LAG_RST  = LAG_W'(16);
  localparam logic [MEM_W-1:0]   MEM_SIZE_RST    = MEM_W'(64'h4000_0000);
  localparam logic [MEM_W-1:0]   MEM_GUARD       = MEM_W'(8'h0f);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_LAG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE    = 2'd2;

  localparam logic OP_SLOT   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_READ  = 2'd2;

  localparam logic [1:0] STOP_RUN      = 2'd0;
  localparam logic [1:0] STOP_END      = 2'd1;
  localparam logic [1:0] STOP_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  end_hit;
    logic [ADDR_OUT_W-1:0] addr;
    logic [KEY_W-1:0]      data;
  } issue_res_t;

  typedef struct packed {
    logic                  active;
    logic                  mismatch;
    logic [ADDR_OUT_W-1:0] addr;
    logic [KEY_W-1:0]      key;
  } check_res_t;

  // One step of the x^64+x^63+x^61+x^60 sequence with inverted feedback.
  function automatic logic [KEY_W-1:0] lfsr_next(input logic [KEY_W-1:0] d);
    logic fb;
    fb = ~(d[0] ^ d[1] ^ d[3] ^ d[4]);
    return {fb, d[KEY_W-1:1]};
  endfunction

  function automatic logic [BLOCK_W:0] block_len(input logic [BLOCK_W-1:0] bw);
    return (bw == '0) ? (BLOCK_W+1)'(1) : {1'b0, bw};
  endfunction

endpackage

[rtl/core/lmts_issue.sv]
// Access slot sequencer: write pointer and key, read pointer, block and lag counts.
// Depends on lmts_pkg.
module lmts_issue import lmts_pkg::*; #(
  parameter int WORD_ADDR_WIDTH = WORD_ADDR_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [BLOCK_W-1:0]         block_words,
  input  logic [LAG_W-1:0]           verify_lag,
  input  logic [MEM_W-1:0]           limit,
  output issue_res_t                 res,
  output logic [WORD_ADDR_WIDTH-1:0] read_pointer
);

  localparam int CmpW = (WORD_ADDR_WIDTH + 3 > MEM_W) ? WORD_ADDR_WIDTH + 3 : MEM_W;

  logic [WORD_ADDR_WIDTH-1:0] write_pointer;
  logic [KEY_W-1:0]           write_key;
  logic [BLOCK_W-1:0]         issue_count;
  logic [LAG_W-1:0]           lag_count;
  logic                       reading;

  logic [BLOCK_W:0]  count_inc;
  logic              block_end;
  logic [LAG_W-1:0]  lag_inc;
  logic [CmpW-1:0]   byte_off;

  always_comb begin
    byte_off  = CmpW'({write_pointer, 3'b000});
    count_inc = {1'b0, issue_count} + (BLOCK_W+1)'(1);
    block_end = count_inc >= block_len(block_words);
    lag_inc   = (lag_count < verify_lag) ? lag_count + LAG_W'(1) : lag_count;
    res = '0;
    if (reading) begin
      res.kind = ACC_READ;
      res.addr = ADDR_OUT_W'(read_pointer);
    end else if (byte_off >= CmpW'(limit)) begin
      res.end_hit = 1'b1;
    end else begin
      res.kind = ACC_WRITE;
      res.addr = ADDR_OUT_W'(write_pointer);
      res.data = write_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      write_key     <= '0;
      read_pointer  <= '0;
      issue_count   <= '0;
      lag_count     <= '0;
      reading       <= 1'b0;
    end else if (go && !res.end_hit) begin
      issue_count <= block_end ? '0 : count_inc[BLOCK_W-1:0];
      if (reading) begin
        read_pointer <= read_pointer + WORD_ADDR_WIDTH'(1);
        if (block_end) begin
          reading <= 1'b0;
        end
      end else begin
        write_pointer <= write_pointer + WORD_ADDR_WIDTH'(1);
        write_key     <= lfsr_next(write_key);
        if (block_end) begin
          lag_count <= lag_inc;
          if (lag_inc == verify_lag) begin
            reading <= 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/core/lmts_check.sv]
// Read data checker: compare pointer and expected key sequence.
// Depends on lmts_pkg.
module lmts_check import lmts_pkg::*; #(
  parameter int WORD_ADDR_WIDTH = WORD_ADDR_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [WORD_ADDR_WIDTH-1:0] read_pointer,
  input  logic [KEY_W-1:0]           read_data,
  output check_res_t                 res
);

  logic [WORD_ADDR_WIDTH-1:0] compare_pointer;
  logic [KEY_W-1:0]           compare_key;

  always_comb begin
    res          = '0;
    res.active   = compare_pointer != read_pointer;
    res.mismatch = read_data != compare_key;
    res.addr     = ADDR_OUT_W'(compare_pointer);
    res.key      = compare_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_pointer <= '0;
      compare_key     <= '0;
    end else if (go && res.active && !res.mismatch) begin
      compare_pointer <= compare_pointer + WORD_ADDR_WIDTH'(1);
      compare_key     <= lfsr_next(compare_key);
    end
  end

endmodule

[rtl/core/lfsr_memory_test_sequencer_unit.sv]
// Top level of the LFSR memory test sequencer: stream ports, configuration and stop state.
// Depends on lmts_pkg, lmts_issue and lmts_check.
// Each input item yields exactly one result item. An item waits in the input register,
// where the slot sequencer or the checker works on it and updates its state as it moves
// on, and then sits in the result register until it is taken, so the block takes one
// item per cycle while the result side is not stalled. The sustained rate is set
// by the single state update per item in the sequencer and checker; a stall on the
// result side holds the input side only once both registers are full.
module lfsr_memory_test_sequencer_unit import lmts_pkg::*; #(
  parameter int WORD_ADDR_WIDTH = WORD_ADDR_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [KEY_W-1:0]       s_tdata,   // read_data
  input  logic                   s_tuser,   // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // word_address, write_data, mismatch, expected_key, stop_status
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser,   // access_kind, check_valid
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [BLOCK_W-1:0] block_words;
  logic [LAG_W-1:0]   verify_lag;
  logic [MEM_W-1:0]   limit;

  logic               in_valid;
  logic               in_opcode;
  logic [KEY_W-1:0]   in_data;
  logic [1:0]         stop_reason;
  logic [1:0]         stop_reason_next;

  logic               advance;
  logic               issue_go;
  logic               check_go;
  issue_res_t         issue_res;
  check_res_t         check_res;
  logic [WORD_ADDR_WIDTH-1:0] read_pointer;

  logic [1:0]            r_kind;
  logic [ADDR_OUT_W-1:0] r_addr;
  logic [KEY_W-1:0]      r_wdata;
  logic                  r_check;
  logic                  r_mismatch;
  logic [KEY_W-1:0]      r_key;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign issue_go = advance && (in_opcode == OP_SLOT) && (stop_reason == STOP_RUN);
  assign check_go = advance && (in_opcode == OP_RETURN) && (stop_reason != STOP_MISMATCH);

  lmts_issue #(.WORD_ADDR_WIDTH(WORD_ADDR_WIDTH)) u_issue (
    .clk          (clk),
    .rst          (rst),
    .go           (issue_go),
    .block_words  (block_words),
    .verify_lag   (verify_lag),
    .limit        (limit),
    .res          (issue_res),
    .read_pointer (read_pointer)
  );

  lmts_check #(.WORD_ADDR_WIDTH(WORD_ADDR_WIDTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .go           (check_go),
    .read_pointer (read_pointer),
    .read_data    (in_data),
    .res          (check_res)
  );

  always_comb begin
    stop_reason_next = stop_reason;
    r_kind     = ACC_NONE;
    r_addr     = '0;
    r_wdata    = '0;
    r_check    = 1'b0;
    r_mismatch = 1'b0;
    r_key      = '0;
    if (issue_go) begin
      r_kind  = issue_res.kind;
      r_addr  = issue_res.addr;
      r_wdata = issue_res.data;
      if (issue_res.end_hit) begin
        stop_reason_next = STOP_END;
      end
    end else if (check_go && check_res.active) begin
      r_addr     = check_res.addr;
      r_check    = 1'b1;
      r_mismatch = check_res.mismatch;
      r_key      = check_res.key;
      if (check_res.mismatch) begin
        stop_reason_next = STOP_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_words <= BLOCK_WORDS_RST;
      verify_lag  <= VERIFY_LAG_RST;
      limit       <= MEM_SIZE_RST - MEM_GUARD;
      in_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      stop_reason <= STOP_RUN;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_WORDS: block_words <= cfg_data[BLOCK_W-1:0];
          CFG_VERIFY_LAG:  verify_lag  <= cfg_data[LAG_W-1:0];
          CFG_MEM_SIZE:    limit <= (cfg_data[MEM_W-1:0] >= MEM_GUARD)
                                    ? cfg_data[MEM_W-1:0] - MEM_GUARD : '0;
          default: ;
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid    <= 1'b1;
        stop_reason <= stop_reason_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode <= s_tuser;
      in_data   <= s_tdata;
    end
    if (advance) begin
      m_tdata <= {stop_reason_next, r_key, r_mismatch, r_wdata, r_addr};
      m_tuser <= {r_check, r_kind};
    end
  end

endmodule

[sim/lfsr_memory_test_sequencer_unit_tb.sv]
// Self-checking testbench for lfsr_memory_test_sequencer_unit.
// Drives slot requests and read returns with random gaps and stalls, and checks every result.
// Depends on lmts_pkg and the RTL of the sequencer unit.
`timescale 1ns / 100ps

module lfsr_memory_test_sequencer_unit_tb;
  import lmts_pkg::*;

  localparam int RAND_ITEMS     = 1400;
  localparam int WD_LO          = ADDR_OUT_W;
  localparam int MIS_BIT        = WD_LO + KEY_W;
  localparam int KEY_LO         = MIS_BIT + 1;
  localparam int STOP_LO        = KEY_LO + KEY_W;
  localparam int IDLE_PCT       = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_OUT_W-1:0] addr;
    logic [KEY_W-1:0]      wdata;
    logic                  chk;
    logic                  mis;
    logic [KEY_W-1:0]      key;
    logic [1:0]            stop;
  } seq_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic {SRC_FIXED, SRC_KEY} data_src_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  op;
    data_src_t             src;
    logic [KEY_W-1:0]      data;
    logic                  has_exp;
    seq_result_t           exp;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [KEY_W-1:0]       s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [BLOCK_W-1:0]             blk_words;
  logic [LAG_W-1:0]               lag_target;
  logic [MEM_W-1:0]               mem_bytes;
  logic [WORD_ADDR_WIDTH_DEF-1:0] wr_ptr;
  logic [WORD_ADDR_WIDTH_DEF-1:0] rd_ptr;
  logic [WORD_ADDR_WIDTH_DEF-1:0] cmp_ptr;
  logic [KEY_W-1:0]               wr_key;
  logic [KEY_W-1:0]               cmp_key;
  logic [BLOCK_W-1:0]             issued;
  logic [BLOCK_W-1:0]             checked;
  logic [LAG_W-1:0]               lag_cnt;
  logic                           reading;
  logic [1:0]                     stop_code;

  seq_result_t pending_results[$];
  dir_row_t    dir_tab[$];
  bit          calm;
  int          errors;
  int          n_items;
  int          n_useful;
  int          n_cfg;
  int          n_writes;
  int          n_reads;
  int          n_checks;

  lfsr_memory_test_sequencer_unit #(
    .WORD_ADDR_WIDTH(WORD_ADDR_WIDTH_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("lfsr_memory_test_sequencer_unit verification failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] key_advance(input logic [KEY_W-1:0] k);
    logic fb;
    fb = 1'b1 ^ (^{k[4], k[3], k[1], k[0]});
    return KEY_W'({fb, k} >> 1);
  endfunction

  function automatic seq_result_t mk_res(input logic [1:0] kind, input logic [ADDR_OUT_W-1:0] addr,
                                         input logic [KEY_W-1:0] wdata);
    seq_result_t r;
    r = '0;
    r.kind = kind;
    r.addr = addr;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic seq_result_t advance_sequencer(input logic op, input logic [KEY_W-1:0] rdata);
    seq_result_t      r;
    logic [MEM_W:0]   lim;
    logic [BLOCK_W:0] len;
    r = '0;
    len = (blk_words == '0) ? (BLOCK_W+1)'(1) : {1'b0, blk_words};
    if (op == OP_SLOT) begin
      if (stop_code == STOP_RUN) begin
        if (!reading) begin
          lim = (mem_bytes >= MEM_GUARD) ? {1'b0, mem_bytes} - {1'b0, MEM_GUARD} : '0;
          if ((MEM_W+1)'({wr_ptr, 3'b000}) >= lim) begin
            stop_code = STOP_END;
          end else begin
            r.kind = ACC_WRITE;
            r.addr = ADDR_OUT_W'(wr_ptr);
            r.wdata = wr_key;
            wr_ptr = wr_ptr + 1'b1;
            wr_key = key_advance(wr_key);
            issued = issued + 1'b1;
            if ({1'b0, issued} >= len) begin
              issued = '0;
              if (lag_cnt < lag_target) lag_cnt = lag_cnt + 1'b1;
              if (lag_cnt == lag_target) reading = 1'b1;
            end
          end
        end else begin
          r.kind = ACC_READ;
          r.addr = ADDR_OUT_W'(rd_ptr);
          rd_ptr = rd_ptr + 1'b1;
          issued = issued + 1'b1;
          if ({1'b0, issued} >= len) begin
            issued = '0;
            reading = 1'b0;
          end
        end
      end
    end else if (stop_code != STOP_MISMATCH && cmp_ptr != rd_ptr) begin
      r.addr = ADDR_OUT_W'(cmp_ptr);
      r.chk = 1'b1;
      r.key = cmp_key;
      if (rdata != cmp_key) begin
        r.mis = 1'b1;
        stop_code = STOP_MISMATCH;
      end else begin
        cmp_ptr = cmp_ptr + 1'b1;
        cmp_key = key_advance(cmp_key);
        checked = checked + 1'b1;
        if ({1'b0, checked} >= len) checked = '0;
      end
    end
    r.stop = stop_code;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic dir_row_t item_row(input logic op, input data_src_t src,
                                        input logic [KEY_W-1:0] data, input logic has_exp,
                                        input seq_result_t exp);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.src = src;
    row.data = data;
    row.has_exp = has_exp;
    row.exp = exp;
    return row;
  endfunction

  task automatic send_item(input logic op, input logic [KEY_W-1:0] data, input logic typed,
                           input seq_result_t typed_res);
    seq_result_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    r = advance_sequencer(op, data);
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
    if (!(op == OP_RETURN && !r.chk)) n_useful++;
  endtask

  // Lower valid and hold off until every expected item has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_BLOCK_WORDS: blk_words = val[BLOCK_W-1:0];
      CFG_VERIFY_LAG:  lag_target = val[LAG_W-1:0];
      CFG_MEM_SIZE:    mem_bytes = val[MEM_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic send_random();
    int roll;
    roll = $urandom_range(0, 99);
    if (rd_ptr != cmp_ptr && roll < 45) begin
      send_item(OP_RETURN, cmp_key, 1'b0, '0);
    end else if (rd_ptr == cmp_ptr && roll < 10) begin
      send_item(OP_RETURN, {$urandom(), $urandom()}, 1'b0, '0);
    end else begin
      send_item(OP_SLOT, {$urandom(), $urandom()}, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    seq_result_t got;
    seq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind  = m_tuser[1:0];
      got.chk   = m_tuser[2];
      got.addr  = m_tdata[ADDR_OUT_W-1:0];
      got.wdata = m_tdata[WD_LO +: KEY_W];
      got.mis   = m_tdata[MIS_BIT];
      got.key   = m_tdata[KEY_LO +: KEY_W];
      got.stop  = m_tdata[STOP_LO +: 2];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result item with nothing expected: kind=%0d addr=%h stop=%0d",
                   got.kind, got.addr, got.stop);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.addr !== want.addr || got.wdata !== want.wdata ||
            got.chk !== want.chk || got.mis !== want.mis || got.key !== want.key ||
            got.stop !== want.stop) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: expected kind=%0d addr=%h wdata=%h chk=%b mis=%b key=%h stop=%0d",
                     want.kind, want.addr, want.wdata, want.chk, want.mis, want.key, want.stop);
            $display("       actual   kind=%0d addr=%h wdata=%h chk=%b mis=%b key=%h stop=%0d",
                     got.kind, got.addr, got.wdata, got.chk, got.mis, got.key, got.stop);
          end
        end else begin
          if (got.kind == ACC_WRITE) n_writes++;
          if (got.kind == ACC_READ) n_reads++;
          if (got.chk) n_checks++;
        end
      end
    end
  end

  initial begin
    dir_row_t         row;
    logic [KEY_W-1:0] data;
    logic [MEM_W-1:0] m;
    int               base;
    int               plen;
    int               roll;
    int               guard;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_SLOT;
    cfg_we = 1'b0;
    cfg_index = CFG_BLOCK_WORDS;
    cfg_data = '0;
    calm = 1'b0;
    errors = 0;
    n_items = 0;
    n_useful = 0;
    n_cfg = 0;
    n_writes = 0;
    n_reads = 0;
    n_checks = 0;
    blk_words = BLOCK_WORDS_RST;
    lag_target = VERIFY_LAG_RST;
    mem_bytes = MEM_SIZE_RST;
    wr_ptr = '0;
    rd_ptr = '0;
    cmp_ptr = '0;
    wr_key = '0;
    cmp_key = '0;
    issued = '0;
    checked = '0;
    lag_cnt = '0;
    reading = 1'b0;
    stop_code = STOP_RUN;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first keys of the sequence are 0, then the top bit, then the top two bits.
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b1,
                               mk_res(ACC_WRITE, ADDR_OUT_W'(0), '0)));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '1, 1'b1,
                               mk_res(ACC_WRITE, ADDR_OUT_W'(1), 64'h8000_0000_0000_0000)));
    dir_tab.push_back(item_row(OP_RETURN, SRC_FIXED, '1, 1'b1, '0));
    dir_tab.push_back(item_row(OP_RETURN, SRC_FIXED, '0, 1'b1, '0));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, 64'h5555_5555_5555_5555, 1'b1,
                               mk_res(ACC_WRITE, ADDR_OUT_W'(2), 64'hC000_0000_0000_0000)));
    dir_tab.push_back(cfg_row(CFG_VERIFY_LAG, '0));
    dir_tab.push_back(cfg_row(CFG_BLOCK_WORDS, '0));
    dir_tab.push_back(cfg_row(CFG_UNUSED_IDX, '1));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_RETURN, SRC_KEY, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_RETURN, SRC_KEY, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_RETURN, SRC_KEY, '0, 1'b0, '0));
    dir_tab.push_back(cfg_row(CFG_MEM_SIZE, 33'h1_0000_0000));
    dir_tab.push_back(cfg_row(CFG_BLOCK_WORDS, 33'h1_0000));
    dir_tab.push_back(cfg_row(CFG_VERIFY_LAG, 33'd255));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '1, 1'b0, '0));
    dir_tab.push_back(item_row(OP_SLOT, SRC_FIXED, '0, 1'b0, '0));
    dir_tab.push_back(item_row(OP_RETURN, SRC_FIXED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0));

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        cfg_write(row.idx, row.val);
      end else begin
        data = (row.src == SRC_KEY) ? cmp_key : row.data;
        send_item(row.op, data, row.has_exp, row.exp);
      end
    end

    base = n_useful;
    while (n_useful - base < RAND_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 2) != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) cfg_write(CFG_BLOCK_WORDS, '0);
        else if (roll < 15) cfg_write(CFG_BLOCK_WORDS, 33'h1_0000);
        else if (roll < 22) cfg_write(CFG_BLOCK_WORDS, CFG_DATA_W'($urandom_range(9, 40)));
        else cfg_write(CFG_BLOCK_WORDS, CFG_DATA_W'($urandom_range(1, 8)));
      end
      if ($urandom_range(0, 1) != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)
          cfg_write(CFG_VERIFY_LAG, (lag_cnt > 252) ? CFG_DATA_W'(255) :
                                    CFG_DATA_W'(lag_cnt + $urandom_range(0, 2)));
        else if (roll < 75 && lag_cnt > 0)
          cfg_write(CFG_VERIFY_LAG, CFG_DATA_W'(lag_cnt - $urandom_range(1, lag_cnt)));
        else if (roll < 85) cfg_write(CFG_VERIFY_LAG, 33'd255);
        else cfg_write(CFG_VERIFY_LAG, CFG_DATA_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
        m = {1'b0, $urandom()};
        if (m < 33'd100000) m = m + 33'd100000;
        if ($urandom_range(0, 9) == 0) m = 33'h1_0000_0000;
        cfg_write(CFG_MEM_SIZE, m);
      end
      plen = (blk_words > 64) ? 25 : $urandom_range(40, 120);
      repeat (plen) begin
        calm = (n_useful - base >= 600) && (n_useful - base < 850);
        send_random();
      end
    end
    calm = 1'b0;

    // Build up outstanding reads, then stop at the end of memory with reads still in flight.
    wait_drained();
    cfg_write(CFG_VERIFY_LAG, CFG_DATA_W'(lag_cnt));
    cfg_write(CFG_BLOCK_WORDS, 33'd2);
    guard = 0;
    while ((rd_ptr - cmp_ptr) < 2 && guard < 40) begin
      send_item(OP_SLOT, {$urandom(), $urandom()}, 1'b0, '0);
      guard++;
    end
    wait_drained();
    if ($urandom_range(0, 1) != 0) begin
      m = MEM_W'($urandom_range(0, 16));
    end else begin
      m = MEM_W'({wr_ptr, 3'b000});
      m = m + MEM_W'(8 * $urandom_range(0, 2)) + MEM_GUARD - MEM_W'($urandom_range(0, 7));
    end
    cfg_write(CFG_MEM_SIZE, m);
    repeat (8) send_item(OP_SLOT, {$urandom(), $urandom()}, 1'b0, '0);
    send_item(OP_RETURN, cmp_key, 1'b0, '0);
    send_item(OP_RETURN, cmp_key ^ ({$urandom(), $urandom()} | 64'd1), 1'b0, '0);
    repeat (10) send_item(1'($urandom_range(0, 1)), {$urandom(), $urandom()}, 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Summary: %0d items sent, %0d register writes, final stop status %0d.",
             n_items, n_cfg, stop_code);
    $display("Summary: %0d writes, %0d reads and %0d returned words checked.",
             n_writes, n_reads, n_checks);
    if (errors == 0) begin
      $display("lfsr_memory_test_sequencer_unit verification clean");
    end else begin
      $display("%0d mismatching result items", errors);
      $display("lfsr_memory_test_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lmts_pkg.sv
rtl/core/lmts_issue.sv
rtl/core/lmts_check.sv
rtl/core/lfsr_memory_test_sequencer_unit.sv
sim/lfsr_memory_test_sequencer_unit_tb.sv
